>>> hdl/qcse_pkg.sv
// Shared types, constants and helpers for the quadrature count speed estimator.
package qcse_pkg;

	localparam int CNT_W   = 16;
	localparam int TS_W    = 64;
	localparam int VAL_W   = 48;
	localparam int CPR_W   = 16;
	localparam int CIRC_W  = 32;
	localparam int ALPHA_W = 17;
	localparam int DEN_W   = 80;
	localparam int NUM_W   = 67;
	localparam int STEP_W  = 7;

	localparam logic [CPR_W-1:0]   CPR_RST   = 16'd8192;
	localparam logic [CIRC_W-1:0]  CIRC_RST  = 32'd5149257;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd19661;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

	localparam logic [1:0] REG_CPR   = 2'd0;
	localparam logic [1:0] REG_CIRC  = 2'd1;
	localparam logic [1:0] REG_ALPHA = 2'd2;

	localparam logic [25:0] RPM_SCALE = 26'd60000000;
	localparam logic [19:0] US_SCALE  = 20'd1000000;

	localparam logic [STEP_W-1:0] STEPS_TURN = 7'd16;
	localparam logic [STEP_W-1:0] STEPS_INC  = 7'd47;
	localparam logic [STEP_W-1:0] STEPS_SPD  = 7'd57;
	localparam logic [STEP_W-1:0] STEPS_VEL  = 7'd67;

	typedef struct packed {
		logic             clear;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] delta;
		logic [CNT_W-1:0] mag;
		logic             neg;
		logic             dt_zero;
		logic [TS_W-1:0]  dt;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [3:0] {
		B_IDLE, B_MUL1, B_MUL2, B_DIV_TURN, B_DIV_INC, B_DIV_SPD, B_DIV_VEL,
		B_FILT1, B_FILT2, B_FILT3, B_OUT
	} back_state_t;

	// Apply sign to a quotient magnitude and saturate to 48 bits.
	function automatic logic [VAL_W-1:0] sat48(input logic [NUM_W-1:0] q, input logic neg);
		logic [NUM_W-1:0] lim;
		logic [NUM_W-1:0] m;
		logic [VAL_W-1:0] mm;
		lim = neg ? (NUM_W'(1) << 47) : ((NUM_W'(1) << 47) - NUM_W'(1));
		m   = (q > lim) ? lim : q;
		mm  = m[VAL_W-1:0];
		return neg ? (~mm + VAL_W'(1)) : mm;
	endfunction

endpackage

>>> hdl/qcse_fifo.sv
// Two-entry item queue between the front and back sections.
module qcse_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qcse_pkg::item_t    wr_item,
	input  logic               pop,
	output qcse_pkg::item_t    rd_item,
	output qcse_pkg::fifo_stat_t stat
);
	import qcse_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign rd_item    = mem_q[rd_ptr_q];
	assign stat.full  = (fill_q == 2'd2);
	assign stat.empty = (fill_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> hdl/qcse_front.sv
// Front section: accepts items, forms count and time differences, queues work.
module qcse_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic [15:0]              count,
	input  logic [63:0]              ts,
	output logic                     push,
	output qcse_pkg::item_t          item,
	input  qcse_pkg::fifo_stat_t     fstat
);
	import qcse_pkg::*;

	logic [CNT_W-1:0] last_count_q;
	logic [TS_W-1:0]  last_time_q;
	logic [CNT_W-1:0] dw;
	logic [TS_W-1:0]  dt;
	logic             acc;

	assign in_ready = !fstat.full;
	assign acc      = in_valid && in_ready;
	assign push     = acc;
	assign dw       = count - last_count_q;
	assign dt       = ts - last_time_q;

	always_comb begin
		item.clear   = mode;
		item.cnt     = mode ? last_count_q : count;
		item.delta   = mode ? '0 : dw;
		item.neg     = !mode && dw[CNT_W-1];
		item.mag     = mode ? '0 : (dw[CNT_W-1] ? (~dw + CNT_W'(1)) : dw);
		item.dt      = dt;
		item.dt_zero = (dt == '0);
	end

	// Advance the sample history on every update item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
			last_time_q  <= '0;
		end else if (acc && !mode) begin
			last_count_q <= count;
			last_time_q  <= ts;
		end
	end

endmodule

>>> hdl/qcse_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module qcse_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qcse_pkg::div_ctl_t        ctl,
	input  logic [66:0]               num,
	input  logic [79:0]               den,
	output logic                      done,
	output logic [66:0]               quo,
	output logic [15:0]               rem
);
	import qcse_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  n_q;
	logic [NUM_W-1:0]  q_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, n_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den});
	assign diff  = trial - {1'b0, den};
	assign done  = done_q;
	assign quo   = q_q;
	assign rem   = rem_q[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
			q_q    <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
				n_q    <= num;
				q_q    <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				n_q   <= n_q << 1;
				q_q   <= {q_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/qcse_back.sv
// Back section: sequences products, divisions, travel and filter per item.
module qcse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qcse_pkg::fifo_stat_t fstat,
	output logic                 pop,
	input  qcse_pkg::item_t      item,
	input  logic [15:0]          cpr,
	input  logic [31:0]          circ,
	input  logic [16:0]          alpha,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          turn_position,
	output logic [15:0]          delta_counts,
	output logic [47:0]          speed_rpm_q16,
	output logic [47:0]          linear_position_q16,
	output logic [47:0]          linear_velocity_q16,
	output logic                 zero_interval
);
	import qcse_pkg::*;

	back_state_t state_q, state_d;
	item_t       it_q;
	logic        issued_q;
	logic        out_valid_q;
	logic        out_load;

	logic [CPR_W-1:0]   cpr_eff;
	logic [ALPHA_W-1:0] alpha_eff;
	logic [47:0]        plo_q;
	logic [DEN_W-1:0]   cprdt_q;
	logic [46:0]        mc_q;
	logic [40:0]        ms_q;
	logic [NUM_W-1:0]   mv_q;
	logic [15:0]        turn_q;
	logic [VAL_W-1:0]   pos_q, filt_q, speed_q, vel_q, inc;
	logic [VAL_W:0]     pos_sum;
	logic signed [65:0] p1_q, p2_q;
	logic signed [66:0] fsum;
	logic signed [66:0] fshift;

	div_ctl_t           dctl;
	logic [NUM_W-1:0]   dnum;
	logic [DEN_W-1:0]   dden;
	logic               ddone;
	logic [NUM_W-1:0]   dquo;
	logic [CNT_W-1:0]   drem;
	logic               in_div;

	logic [47:0] mc_full;
	logic [67:0] mv_full;
	logic [41:0] ms_full;
	logic [47:0] phi_full;

	assign cpr_eff   = (cpr == '0) ? CPR_W'(1) : cpr;
	assign alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
	assign mc_full   = it_q.mag * circ;
	assign ms_full   = it_q.mag * RPM_SCALE;
	assign mv_full   = {20'b0, mc_q} * US_SCALE;
	assign phi_full  = cpr_eff * it_q.dt[63:32];
	assign inc       = sat48(dquo, it_q.neg);
	assign pos_sum   = {pos_q[VAL_W-1], pos_q} + {inc[VAL_W-1], inc};
	assign fsum      = {p1_q[65], p1_q} + {p2_q[65], p2_q};
	assign fshift    = fsum[66] ? ((fsum + 67'sd65535) >>> 16) : (fsum >>> 16);

	assign in_div = (state_q == B_DIV_TURN) || (state_q == B_DIV_INC) ||
	                (state_q == B_DIV_SPD) || (state_q == B_DIV_VEL);

	qcse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.num    (dnum),
		.den    (dden),
		.done   (ddone),
		.quo    (dquo),
		.rem    (drem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:     if (!fstat.empty) state_d = B_MUL1;
			B_MUL1:     state_d = B_MUL2;
			B_MUL2:     state_d = B_DIV_TURN;
			B_DIV_TURN: if (ddone) state_d = it_q.clear ? B_OUT : B_DIV_INC;
			B_DIV_INC:  if (ddone) state_d = it_q.dt_zero ? B_FILT1 : B_DIV_SPD;
			B_DIV_SPD:  if (ddone) state_d = B_DIV_VEL;
			B_DIV_VEL:  if (ddone) state_d = B_FILT1;
			B_FILT1:    state_d = B_FILT2;
			B_FILT2:    state_d = B_FILT3;
			B_FILT3:    state_d = B_OUT;
			B_OUT:      if (out_load) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	// Control outputs and divider operand selection.
	always_comb begin
		pop        = (state_q == B_IDLE) && !fstat.empty;
		out_load   = (state_q == B_OUT) && (!out_valid_q || out_ready);
		dctl.start = in_div && !issued_q;
		dctl.steps = STEPS_TURN;
		dnum       = {it_q.cnt, 51'b0};
		dden       = {64'b0, cpr_eff};
		case (state_q)
			B_DIV_INC: begin
				dctl.steps = STEPS_INC;
				dnum       = {mc_q, 20'b0};
			end
			B_DIV_SPD: begin
				dctl.steps = STEPS_SPD;
				dnum       = {ms_q, 26'b0};
				dden       = cprdt_q;
			end
			B_DIV_VEL: begin
				dctl.steps = STEPS_VEL;
				dnum       = mv_q;
				dden       = cprdt_q;
			end
			default: begin
				dctl.steps = STEPS_TURN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			filt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (dctl.start) issued_q <= 1'b1;
			else if (ddone) issued_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			// Clear travel on a clear item, else accumulate the saturated increment.
			if (state_q == B_DIV_TURN && ddone && it_q.clear) pos_q <= '0;
			if (state_q == B_DIV_INC && ddone) begin
				if (pos_sum[VAL_W] != pos_sum[VAL_W-1])
					pos_q <= pos_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
					                        : {1'b0, {(VAL_W-1){1'b1}}};
				else
					pos_q <= pos_sum[VAL_W-1:0];
			end
			if (state_q == B_FILT3) filt_q <= fshift[VAL_W-1:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (pop) it_q <= item;
		case (state_q)
			B_MUL1: begin
				plo_q   <= cpr_eff * it_q.dt[31:0];
				mc_q    <= mc_full[46:0];
				ms_q    <= ms_full[40:0];
				speed_q <= '0;
				vel_q   <= '0;
			end
			B_MUL2: begin
				cprdt_q <= {32'b0, plo_q} + {phi_full, 32'b0};
				mv_q    <= mv_full[NUM_W-1:0];
			end
			B_DIV_TURN: if (ddone) turn_q <= drem;
			B_DIV_SPD:  if (ddone) speed_q <= sat48(dquo, it_q.neg);
			B_DIV_VEL:  if (ddone) vel_q <= sat48(dquo, it_q.neg);
			B_FILT1:    p1_q <= $signed({1'b0, alpha_eff}) * $signed(vel_q);
			B_FILT2:    p2_q <= $signed({1'b0, ALPHA_ONE - alpha_eff}) * $signed(filt_q);
			default: begin
			end
		endcase
		if (out_load) begin
			turn_position       <= turn_q;
			delta_counts        <= it_q.delta;
			speed_rpm_q16       <= speed_q;
			linear_position_q16 <= it_q.clear ? '0 : pos_q;
			linear_velocity_q16 <= filt_q;
			zero_interval       <= !it_q.clear && it_q.dt_zero;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/quadrature_count_speed_estimator_core.sv
// Top level of the quadrature count speed estimator.
//
// Usage: each input transaction on s_* carries a counter sample (tuser = 0)
// or a clear-travel command (tuser = 1). Each one produces exactly one output
// transaction on m_* with turn position, count delta, speed in rpm, linear
// travel and filtered linear velocity, all rates signed Q32.16.
// Configuration registers (counts per rev, circumference, filter weight) are
// written through cfg_wr_en/cfg_index/cfg_wdata while the block is idle.
// The bit-serial divider serves up to four divisions (16, 47, 57 and 67
// quotient bits) per sample; a zero interval runs only the first two and
// a clear only the first. The back handles one item at a time; the front
// accepts into a two-entry queue, so up to two items are taken while the
// back works.
// Reset clears history, travel and filter state and loads register defaults.
// When m_tready is low the result holds in the output register; the back
// waits there, the queue fills, then s_tready drops.
module quadrature_count_speed_estimator_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // count[15:0], timestamp_us[79:16]
	input  logic         s_tuser,   // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata,   // turn_position, delta_counts, speed_rpm_q16,
	                                // linear_position_q16, linear_velocity_q16
	output logic         m_tuser,   // zero_interval
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	import qcse_pkg::*;

	logic [CPR_W-1:0]   cpr_q;
	logic [CIRC_W-1:0]  circ_q;
	logic [ALPHA_W-1:0] alpha_q;

	item_t      push_item, pop_item;
	fifo_stat_t fstat;
	logic       push, pop;

	logic [15:0] turn_position, delta_counts;
	logic [47:0] speed_rpm_q16, linear_position_q16, linear_velocity_q16;

	// Register writes; out-of-range indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q   <= CPR_RST;
			circ_q  <= CIRC_RST;
			alpha_q <= ALPHA_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CPR:   cpr_q   <= cfg_wdata[CPR_W-1:0];
				REG_CIRC:  circ_q  <= cfg_wdata;
				REG_ALPHA: alpha_q <= cfg_wdata[ALPHA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	qcse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.mode     (s_tuser),
		.count    (s_tdata[15:0]),
		.ts       (s_tdata[79:16]),
		.push     (push),
		.item     (push_item),
		.fstat    (fstat)
	);

	qcse_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.rd_item (pop_item),
		.stat    (fstat)
	);

	qcse_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.fstat               (fstat),
		.pop                 (pop),
		.item                (pop_item),
		.cpr                 (cpr_q),
		.circ                (circ_q),
		.alpha               (alpha_q),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.turn_position       (turn_position),
		.delta_counts        (delta_counts),
		.speed_rpm_q16       (speed_rpm_q16),
		.linear_position_q16 (linear_position_q16),
		.linear_velocity_q16 (linear_velocity_q16),
		.zero_interval       (m_tuser)
	);

	assign m_tdata = {linear_velocity_q16, linear_position_q16, speed_rpm_q16,
	                  delta_counts, turn_position};

	// A zero interval always reports zero speed.
	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[79:32] == 48'd0)
		else $error("zero interval with nonzero speed");

	// Queue status stays consistent.
	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fstat.full && fstat.empty))
		else $error("queue both full and empty");

	// Nothing is pushed into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fstat.full)
		else $error("queue overflow");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the quadrature count speed estimator core.
`timescale 1ns / 1ps
module tb;
	import qcse_pkg::*;

	localparam longint POS_MAX = 64'sd140737488355327;
	localparam longint NEG_MIN = -64'sd140737488355328;
	localparam int LIMIT_CYCLES = 1500000;

	typedef struct {
		logic [15:0] turn;
		logic [15:0] delta;
		logic [47:0] speed;
		logic [47:0] travel;
		logic [47:0] velocity;
		logic        zero_dt;
	} estimate_t;

	// Apply sign to a magnitude and saturate to the 48-bit range.
	function automatic longint clamp_mag(input logic [191:0] mag, input bit neg);
		logic [191:0] lim;
		lim = neg ? 192'(64'd140737488355328) : 192'(64'd140737488355327);
		if (mag > lim) mag = lim;
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	class estimate_board;
		estimate_t pending[$];
		int errors;
		logic [15:0] cpr;
		logic [31:0] circ;
		logic [16:0] alpha;
		logic [15:0] prev_count;
		logic [63:0] prev_time;
		longint travel;
		longint velocity;

		function void reset_state();
			cpr = CPR_RST; circ = CIRC_RST; alpha = ALPHA_RST;
			prev_count = '0; prev_time = '0; travel = 0; velocity = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_CPR:   cpr = val[15:0];
				REG_CIRC:  circ = val;
				REG_ALPHA: alpha = val[16:0];
				default: ;
			endcase
		endfunction

		// Predict the result of one accepted input transaction.
		function void note_input(bit clr, logic [15:0] cnt, logic [63:0] ts);
			estimate_t e;
			logic [191:0] c, a, dt, m, num;
			logic [63:0] dt64;
			logic [15:0] dw;
			longint dl, inc, vel, spd;
			bit neg;
			c = (cpr == 0) ? 1 : cpr;
			a = (alpha > ALPHA_ONE) ? 192'(65536) : 192'(alpha);
			e.delta = 0; e.speed = 0; e.zero_dt = 0;
			if (clr) begin
				travel = 0;
				e.turn = 16'(192'(prev_count) % c);
			end else begin
				dt64 = ts - prev_time;
				dt = 192'(dt64);
				dw = cnt - prev_count;
				dl = longint'($signed(dw));
				neg = dl < 0;
				m = neg ? 192'(-dl) : 192'(dl);
				e.delta = dw;
				e.turn = 16'(192'(cnt) % c);
				num = (m * 192'(circ)) << 16;
				inc = clamp_mag(num / (c << 16), neg);
				travel = travel + inc;
				if (travel > POS_MAX) travel = POS_MAX;
				if (travel < NEG_MIN) travel = NEG_MIN;
				vel = 0;
				if (dt == 0) begin
					e.zero_dt = 1;
				end else begin
					spd = clamp_mag(((m * 192'(60000000)) << 16) / (c * dt), neg);
					e.speed = spd[47:0];
					num = ((m * 192'(1000000)) * 192'(circ)) << 16;
					vel = clamp_mag(num / ((c * dt) << 16), neg);
				end
				velocity = (longint'(a) * vel + (65536 - longint'(a)) * velocity) / 65536;
				prev_count = cnt;
				prev_time = ts;
			end
			e.travel = travel[47:0];
			e.velocity = velocity[47:0];
			pending.push_back(e);
		endfunction

		function void check_result(logic [175:0] d, logic zi);
			estimate_t e;
			if (pending.size() == 0) begin
				$error("result with no expectation");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[15:0] !== e.turn) begin
				$error("turn_position exp %0d got %0d", e.turn, d[15:0]); errors++;
			end
			if (d[31:16] !== e.delta) begin
				$error("delta_counts exp %0h got %0h", e.delta, d[31:16]); errors++;
			end
			if (d[79:32] !== e.speed) begin
				$error("speed_rpm_q16 exp %0h got %0h", e.speed, d[79:32]); errors++;
			end
			if (d[127:80] !== e.travel) begin
				$error("linear_position_q16 exp %0h got %0h", e.travel, d[127:80]); errors++;
			end
			if (d[175:128] !== e.velocity) begin
				$error("linear_velocity_q16 exp %0h got %0h", e.velocity, d[175:128]);
				errors++;
			end
			if (zi !== e.zero_dt) begin
				$error("zero_interval exp %0b got %0b", e.zero_dt, zi); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
	logic [79:0] s_tdata = '0;
	logic s_tready, m_tvalid, m_tuser;
	logic [175:0] m_tdata;
	logic cfg_wr_en = 0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	estimate_board board;
	int cycles = 0;
	int hold_off = 0;
	bit stall_on = 1;
	logic [15:0] run_count = 0;
	logic [63:0] run_time = 0;

	always #2 clk = ~clk;

	quadrature_count_speed_estimator_core DUT (.*);

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: stall pattern, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else
			m_tready <= stall_on ? (($urandom & 7) != 0) : 1'b1;
	end

	// Offer one transaction; valid stays high so the next send can follow directly.
	task automatic send(bit clr, logic [15:0] cnt, logic [63:0] ts);
		s_tvalid <= 1; s_tuser <= clr; s_tdata <= {ts, cnt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(clr, cnt, ts);
	endtask

	// Random gap between bursts.
	task automatic gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
		if (n > 0) begin
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
		cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		board.write_reg(idx, val);
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	// Motion with count steps up to maxstep and advancing time, plus occasional clears, random jumps and zero intervals.
	task automatic burst(int n, int maxstep);
		repeat (n) begin
			int r;
			r = $urandom_range(0, 19);
			if (r == 0) send(1, $urandom, {$urandom, $urandom});
			else if (r == 1) send(0, $urandom, {$urandom, $urandom});
			else begin
				run_count = run_count + 16'($signed($urandom_range(0, 2 * maxstep)) - maxstep);
				if (r != 2) run_time = run_time + $urandom_range(1, 20000);
				send(0, run_count, run_time);
			end
		end
	endtask

	initial begin
		board = new();
		board.reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, clear, zero interval, backward time.
		send(0, 16'h0000, 64'd0);
		send(0, 16'h7FFF, 64'd1);
		send(0, 16'hFFFF, 64'd1);
		send(0, 16'h8000, 64'hFFFF_FFFF_FFFF_FFFF);
		send(0, 16'h0001, 64'd0);
		send(1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send(0, 16'hAAAA, 64'h5555_5555_5555_5555);
		send(0, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send(0, 16'h5556, 64'hAAAA_AAAA_AAAA_AAAB);
		drain();

		// Extreme settings: huge and zero circumference, cpr 0, 1 and 65535, alpha edges.
		write_cfg(REG_CPR, 32'd0);
		write_cfg(REG_CIRC, 32'hFFFF_FFFF);
		write_cfg(REG_ALPHA, 32'h1FFFF);
		write_cfg(2'd3, 32'hFFFF_FFFF);
		send(0, 16'h7FFF, 64'h1_0000_0000);
		send(0, 16'hFFFF, 64'h1_0000_0001);
		send(0, 16'h7FFF, 64'h1_0000_0002);
		send(0, 16'h8000, 64'h1_0000_0002);
		drain();
		write_cfg(REG_CPR, 32'd65535);
		write_cfg(REG_CIRC, 32'd0);
		write_cfg(REG_ALPHA, 32'd0);
		send(0, 16'hFFFF, 64'd50);
		send(0, 16'h0000, 64'd40);
		drain();
		write_cfg(REG_CPR, 32'd1);
		write_cfg(REG_CIRC, 32'd65536);
		write_cfg(REG_ALPHA, 32'd65536);
		send(0, 16'h1234, 64'd100);
		send(1, 16'h0, 64'd0);
		drain();

		// Random phases over several register settings.
		for (int ph = 0; ph < 5; ph++) begin
			write_cfg(REG_CPR, $urandom_range(1, 65535));
			write_cfg(REG_CIRC, $urandom);
			write_cfg(REG_ALPHA, $urandom_range(0, 70000));
			stall_on = (ph != 2);
			for (int b = 0; b < 12; b++) begin
				burst($urandom_range(1, 20), (b % 3 == 0) ? 32767 : 200);
				gap();
				if (ph == 1 && b == 4) hold_off = 3000;
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
